[src/fdsb_pkg.sv]
package fdsb_pkg;

   localparam int unsigned DigitWidth      = 4;
   localparam int unsigned SelectWidth     = 2;
   localparam int unsigned ModeWidth       = 2;
   localparam int unsigned ScanPeriodWidth = 8;
   localparam int unsigned BlinkPerWidth   = 12;
   localparam int unsigned ScanCountWidth  = 9;
   localparam int unsigned BlinkCntWidth   = 13;
   localparam int unsigned CsrIndexWidth   = 2;
   localparam int unsigned CsrDataWidth    = 12;
   localparam int unsigned ReqDataWidth    = 16;
   localparam int unsigned RspDataWidth    = 8;

   localparam logic [CsrIndexWidth-1:0] CSR_DISPLAY_MODE = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_DISPLAY_ON   = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_SCAN_PERIOD  = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_BLINK_PERIOD = 2'd3;

   localparam logic [ModeWidth-1:0] MODE_NORMAL       = 2'd0;
   localparam logic [ModeWidth-1:0] MODE_HOUR_BLINK   = 2'd1;
   localparam logic [ModeWidth-1:0] MODE_MINUTE_BLINK = 2'd2;

   localparam logic [SelectWidth-1:0] SEL_MINUTE_UNITS = 2'd0;
   localparam logic [SelectWidth-1:0] SEL_MINUTE_TENS  = 2'd1;
   localparam logic [SelectWidth-1:0] SEL_HOUR_UNITS   = 2'd2;
   localparam logic [SelectWidth-1:0] SEL_HOUR_TENS    = 2'd3;

   localparam logic [ScanCountWidth-1:0]  SCAN_COUNT_MAX     = 9'd511;
   localparam logic [BlinkCntWidth-1:0]   BLINK_COUNT_MAX    = 13'd8191;
   localparam logic [ScanPeriodWidth-1:0] SCAN_PERIOD_RESET  = 8'd2;
   localparam logic [BlinkPerWidth-1:0]   BLINK_PERIOD_RESET = 12'd300;

   typedef struct packed {
      logic [ModeWidth-1:0]       display_mode;
      logic                       display_on;
      logic [ScanPeriodWidth-1:0] scan_period;
      logic [BlinkPerWidth-1:0]   blink_period;
   } cfg_type;

   typedef struct packed {
      logic [DigitWidth-1:0] minute_units;
      logic [DigitWidth-1:0] minute_tens;
      logic [DigitWidth-1:0] hour_units;
      logic [DigitWidth-1:0] hour_tens;
   } digits_type;

   typedef struct packed {
      logic [DigitWidth-1:0]  shown_digit;
      logic                   digit_enable;
      logic [SelectWidth-1:0] digit_select;
   } disp_type;

endpackage

[src/fdsb_scan_state.sv]
module fdsb_scan_state (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tick,
   input  logic                 mode_write,
   input  fdsb_pkg::cfg_type    cfg,
   input  fdsb_pkg::digits_type digits,
   output fdsb_pkg::disp_type   disp_in
);

   logic [fdsb_pkg::SelectWidth-1:0]    scan_index_ff, scan_index_in;
   logic [fdsb_pkg::ScanCountWidth-1:0] scan_count_ff, scan_count_in, scan_inc;
   logic [fdsb_pkg::BlinkCntWidth-1:0]  blink_count_ff, blink_count_in, blink_inc;
   logic                                hours_visible_ff, hours_visible_in;
   logic                                minutes_visible_ff, minutes_visible_in;
   logic                                enable_latch_ff, enable_latch_in;
   logic [fdsb_pkg::DigitWidth-1:0]     digit_latch_ff, digit_latch_in;
   logic                                blink_due, scan_due, group_visible;
   logic [fdsb_pkg::SelectWidth-1:0]    next_index;
   logic [fdsb_pkg::DigitWidth-1:0]     next_digit;

   always_comb begin
      blink_inc = (blink_count_ff == fdsb_pkg::BLINK_COUNT_MAX) ?
                  blink_count_ff : blink_count_ff + 1'b1;
      scan_inc  = (scan_count_ff == fdsb_pkg::SCAN_COUNT_MAX) ?
                  scan_count_ff : scan_count_ff + 1'b1;
      blink_due = blink_inc > {1'b0, cfg.blink_period};
      scan_due  = scan_inc > {1'b0, cfg.scan_period};
      next_index = scan_index_ff + 1'b1;

      hours_visible_in   = hours_visible_ff;
      minutes_visible_in = minutes_visible_ff;
      blink_count_in     = blink_inc;
      if (cfg.display_mode == fdsb_pkg::MODE_HOUR_BLINK && blink_due) begin
         hours_visible_in = ~hours_visible_ff;
         blink_count_in   = '0;
      end else if (cfg.display_mode == fdsb_pkg::MODE_MINUTE_BLINK && blink_due) begin
         minutes_visible_in = ~minutes_visible_ff;
         blink_count_in     = '0;
      end

      unique case (next_index)
         fdsb_pkg::SEL_MINUTE_UNITS: begin
            next_digit    = digits.minute_units;
            group_visible = minutes_visible_in;
         end
         fdsb_pkg::SEL_MINUTE_TENS: begin
            next_digit    = digits.minute_tens;
            group_visible = minutes_visible_in;
         end
         fdsb_pkg::SEL_HOUR_UNITS: begin
            next_digit    = digits.hour_units;
            group_visible = hours_visible_in;
         end
         fdsb_pkg::SEL_HOUR_TENS: begin
            next_digit    = digits.hour_tens;
            group_visible = hours_visible_in;
         end
         default: begin
            next_digit    = digits.minute_units;
            group_visible = minutes_visible_in;
         end
      endcase

      if (scan_due) begin
         scan_index_in   = next_index;
         digit_latch_in  = next_digit;
         enable_latch_in = group_visible & cfg.display_on;
         scan_count_in   = '0;
      end else begin
         scan_index_in   = scan_index_ff;
         digit_latch_in  = digit_latch_ff;
         enable_latch_in = enable_latch_ff;
         scan_count_in   = scan_inc;
      end

      disp_in.digit_select = scan_index_in;
      disp_in.digit_enable = enable_latch_in;
      disp_in.shown_digit  = digit_latch_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_index_ff      <= fdsb_pkg::SEL_MINUTE_UNITS;
         scan_count_ff      <= '0;
         blink_count_ff     <= '0;
         hours_visible_ff   <= 1'b1;
         minutes_visible_ff <= 1'b1;
         enable_latch_ff    <= 1'b0;
         digit_latch_ff     <= '0;
      end else if (mode_write) begin
         hours_visible_ff   <= 1'b1;
         minutes_visible_ff <= 1'b1;
         blink_count_ff     <= '0;
      end else if (tick) begin
         scan_index_ff      <= scan_index_in;
         scan_count_ff      <= scan_count_in;
         blink_count_ff     <= blink_count_in;
         hours_visible_ff   <= hours_visible_in;
         minutes_visible_ff <= minutes_visible_in;
         enable_latch_ff    <= enable_latch_in;
         digit_latch_ff     <= digit_latch_in;
      end
   end

endmodule

[src/four_digit_scan_blink_driver_core.sv]
// Drives a four-digit multiplexed display from one tick transfer per millisecond, each
// carrying the BCD hour and minute digits; every accepted tick yields exactly one result
// transfer with the active digit, its drive enable and the latched BCD value. A tick is
// accepted every clock cycle while req_tready is high, and its result is captured in the
// output register, which holds it while the result side stalls; the input side accepts
// as long as that register is empty or being emptied in the same cycle. Configuration
// writes take effect on the clock edge at which they are written.
module four_digit_scan_blink_driver_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // Fields from bit 0: hour_tens, hour_units, minute_tens, minute_units.
   input  logic [fdsb_pkg::ReqDataWidth-1:0]    req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // Fields from bit 0: digit_select, digit_enable, shown_digit, one zero pad bit.
   output logic [fdsb_pkg::RspDataWidth-1:0]    rsp_tdata,
   input  logic                                 csr_we,
   input  logic [fdsb_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [fdsb_pkg::CsrDataWidth-1:0]    csr_wdata
);

   fdsb_pkg::cfg_type    cfg_ff;
   fdsb_pkg::digits_type digits;
   fdsb_pkg::disp_type   disp_in, rsp_data_ff;
   logic                 rsp_valid_ff;
   logic                 req_accept, mode_write;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_accept = req_tvalid & req_tready;
   assign mode_write = csr_we && (csr_index == fdsb_pkg::CSR_DISPLAY_MODE);

   assign digits.hour_tens    = req_tdata[3:0];
   assign digits.hour_units   = req_tdata[7:4];
   assign digits.minute_tens  = req_tdata[11:8];
   assign digits.minute_units = req_tdata[15:12];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.display_mode <= fdsb_pkg::MODE_NORMAL;
         cfg_ff.display_on   <= 1'b1;
         cfg_ff.scan_period  <= fdsb_pkg::SCAN_PERIOD_RESET;
         cfg_ff.blink_period <= fdsb_pkg::BLINK_PERIOD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            fdsb_pkg::CSR_DISPLAY_MODE:
               cfg_ff.display_mode <= csr_wdata[fdsb_pkg::ModeWidth-1:0];
            fdsb_pkg::CSR_DISPLAY_ON:
               cfg_ff.display_on <= csr_wdata[0];
            fdsb_pkg::CSR_SCAN_PERIOD:
               cfg_ff.scan_period <= csr_wdata[fdsb_pkg::ScanPeriodWidth-1:0];
            fdsb_pkg::CSR_BLINK_PERIOD:
               cfg_ff.blink_period <= csr_wdata[fdsb_pkg::BlinkPerWidth-1:0];
            default: ;
         endcase
      end
   end

   fdsb_scan_state u_scan_state (
      .clock      (clock),
      .reset      (reset),
      .tick       (req_accept),
      .mode_write (mode_write),
      .cfg        (cfg_ff),
      .digits     (digits),
      .disp_in    (disp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= disp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

endmodule

[src/fdsb_checker.sv]
module fdsb_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [fdsb_pkg::RspDataWidth-1:0]    rsp_tdata
);

   // A stalled result keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Every accepted tick produces a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted tick produced no result");

   // An empty output register never blocks the input side.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // With no tick accepted, a taken result is not followed by another.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !(req_tvalid && req_tready) |=> !rsp_tvalid)
      else $error("result repeated without a tick");

endmodule

bind four_digit_scan_blink_driver_core fdsb_checker u_fdsb_checker (.*);

[verif/tb_four_digit_scan_blink_driver_core.sv]
`timescale 1ns / 100ps

module tb_four_digit_scan_blink_driver_core;
   import fdsb_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_TICKS   = 2000;
   localparam int PRINT_CAP      = 40;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [ReqDataWidth-1:0]  req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RspDataWidth-1:0]  rsp_tdata;
   logic                     csr_we = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   four_digit_scan_blink_driver_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state of the display scanner.
   cfg_type                    cfg_model;
   logic [SelectWidth-1:0]     sel_now;
   logic [ScanCountWidth-1:0]  scan_cnt;
   logic [BlinkCntWidth-1:0]   blink_cnt;
   logic                       hours_vis;
   logic                       minutes_vis;
   logic                       enable_now;
   logic [DigitWidth-1:0]      digit_now;

   digits_type tick_q[$];
   disp_type   expected_disp_q[$];

   int  ticks_queued = 0;
   int  ticks_accepted = 0;
   int  results_checked = 0;
   int  mismatch_count = 0;
   int  switch_count = 0;
   int  toggle_count = 0;
   int  csr_writes = 0;
   int  phase_count = 0;
   int  idle_cycles = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   int  send_gap_pct = 0;
   int  recv_gap_pct = 0;
   bit  req_took = 1'b0;

   function automatic disp_type scan_tick(input digits_type d);
      logic     vis;
      disp_type res;
      vis = 1'b0;
      if (blink_cnt != BLINK_COUNT_MAX) blink_cnt = blink_cnt + 1'b1;
      if (scan_cnt != SCAN_COUNT_MAX) scan_cnt = scan_cnt + 1'b1;
      if (cfg_model.display_mode == MODE_HOUR_BLINK && blink_cnt > cfg_model.blink_period) begin
         hours_vis = ~hours_vis;
         blink_cnt = '0;
         toggle_count++;
      end else if (cfg_model.display_mode == MODE_MINUTE_BLINK &&
                   blink_cnt > cfg_model.blink_period) begin
         minutes_vis = ~minutes_vis;
         blink_cnt = '0;
         toggle_count++;
      end
      if (scan_cnt > cfg_model.scan_period) begin
         sel_now = sel_now + 1'b1;
         case (sel_now)
            SEL_MINUTE_UNITS: begin
               digit_now = d.minute_units;
               vis = minutes_vis;
            end
            SEL_MINUTE_TENS: begin
               digit_now = d.minute_tens;
               vis = minutes_vis;
            end
            SEL_HOUR_UNITS: begin
               digit_now = d.hour_units;
               vis = hours_vis;
            end
            default: begin
               digit_now = d.hour_tens;
               vis = hours_vis;
            end
         endcase
         enable_now = vis & cfg_model.display_on;
         scan_cnt = '0;
         switch_count++;
      end
      res.digit_select = sel_now;
      res.digit_enable = enable_now;
      res.shown_digit  = digit_now;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < PRINT_CAP) begin
         $display("%0t: result %0d: %s is %0d, expected %0d", $realtime, results_checked,
                  what, got, want);
      end
      mismatch_count++;
   endtask

   // Monitor: predicts on every accepted tick and checks every accepted result.
   always @(posedge clock) begin
      disp_type got;
      disp_type want;
      req_took = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_disp_q.push_back(scan_tick(digits_type'(req_tdata)));
            ticks_accepted++;
            req_took = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_disp_q.size() == 0) begin
               report_mismatch("unexpected transfer, select", rsp_tdata[1:0], -1);
            end else begin
               got  = rsp_tdata[6:0];
               want = expected_disp_q.pop_front();
               if (got.digit_select !== want.digit_select)
                  report_mismatch("digit_select", got.digit_select, want.digit_select);
               if (got.digit_enable !== want.digit_enable)
                  report_mismatch("digit_enable", got.digit_enable, want.digit_enable);
               if (got.shown_digit !== want.shown_digit)
                  report_mismatch("shown_digit", got.shown_digit, want.shown_digit);
               if (rsp_tdata[7] !== 1'b0)
                  report_mismatch("pad bit", rsp_tdata[7], 0);
            end
            results_checked++;
         end
      end
   end

   // Tick driver with random idle bursts.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (!(req_tvalid && !req_took)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (tick_q.size() > 0 && send_gap_pct != 0 &&
                      $urandom_range(99) < send_gap_pct) begin
            send_gap = $urandom_range(5, 1) - 1;
            req_tvalid <= 1'b0;
         end else if (tick_q.size() > 0) begin
            req_tdata  <= tick_q.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result side with random stall bursts.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap = 0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_tready <= 1'b0;
      end else if (recv_gap_pct != 0 && $urandom_range(99) < recv_gap_pct) begin
         recv_gap = $urandom_range(5, 1) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("No transfer for %0d cycles; %0d results still outstanding.",
                     idle_cycles, expected_disp_q.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   function automatic digits_type make_digits(input int ht, input int hu, input int mt,
                                              input int mu);
      digits_type d;
      d.hour_tens    = ht;
      d.hour_units   = hu;
      d.minute_tens  = mt;
      d.minute_units = mu;
      return d;
   endfunction

   function automatic logic [DigitWidth-1:0] random_digit();
      if ($urandom_range(99) < 15) return $urandom_range(15, 10);
      return $urandom_range(9, 0);
   endfunction

   task automatic push_tick(input digits_type d);
      tick_q.push_back(d);
      ticks_queued++;
   endtask

   task automatic push_random_ticks(input int n);
      for (int i = 0; i < n; i++) begin
         push_tick(make_digits(random_digit(), random_digit(), random_digit(),
                               random_digit()));
      end
   endtask

   // Waits until every tick has been taken and every result checked.
   task automatic wait_drained();
      while (ticks_accepted != ticks_queued || expected_disp_q.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      phase_count++;
   endtask

   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_DISPLAY_MODE: begin
            cfg_model.display_mode = value[ModeWidth-1:0];
            hours_vis   = 1'b1;
            minutes_vis = 1'b1;
            blink_cnt   = '0;
         end
         CSR_DISPLAY_ON:  cfg_model.display_on = value[0];
         CSR_SCAN_PERIOD: cfg_model.scan_period = value[ScanPeriodWidth-1:0];
         default:         cfg_model.blink_period = value[BlinkPerWidth-1:0];
      endcase
      csr_writes++;
   endtask

   task automatic close_csr();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [CsrDataWidth-1:0] with_noise(input int value, input int width);
      logic [CsrDataWidth-1:0] v;
      v = $urandom;
      v = (v >> width) << width;
      return v | value;
   endfunction

   initial begin
      int n;
      cfg_model.display_mode = MODE_NORMAL;
      cfg_model.display_on   = 1'b1;
      cfg_model.scan_period  = SCAN_PERIOD_RESET;
      cfg_model.blink_period = BLINK_PERIOD_RESET;
      sel_now     = SEL_MINUTE_UNITS;
      scan_cnt    = '0;
      blink_cnt   = '0;
      hours_vis   = 1'b1;
      minutes_vis = 1'b1;
      enable_now  = 1'b0;
      digit_now   = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: extreme and non-BCD digit values.
      push_tick(make_digits(0, 0, 0, 0));
      push_tick(make_digits(9, 9, 9, 9));
      push_tick(make_digits(15, 15, 15, 15));
      push_tick(make_digits(1, 2, 3, 4));
      push_tick(make_digits(5, 6, 7, 8));
      push_tick(make_digits(10, 11, 12, 13));
      push_tick(make_digits(14, 15, 10, 11));
      push_tick(make_digits(2, 3, 5, 9));
      push_tick(make_digits(0, 9, 0, 9));
      push_tick(make_digits(9, 0, 9, 0));
      push_tick(make_digits(8, 4, 2, 1));
      push_tick(make_digits(1, 2, 4, 8));
      wait_drained();

      // Hour group blinking on every tick with the fastest scan.
      write_csr(CSR_SCAN_PERIOD, 0);
      write_csr(CSR_BLINK_PERIOD, 0);
      write_csr(CSR_DISPLAY_MODE, MODE_HOUR_BLINK);
      close_csr();
      push_random_ticks(40);
      wait_drained();

      write_csr(CSR_SCAN_PERIOD, 1);
      write_csr(CSR_BLINK_PERIOD, 3);
      write_csr(CSR_DISPLAY_MODE, MODE_MINUTE_BLINK);
      close_csr();
      push_random_ticks(40);
      wait_drained();

      // The unused mode must not blink either group.
      write_csr(CSR_SCAN_PERIOD, 0);
      write_csr(CSR_BLINK_PERIOD, 0);
      write_csr(CSR_DISPLAY_MODE, 3);
      close_csr();
      push_random_ticks(20);
      wait_drained();

      write_csr(CSR_DISPLAY_MODE, MODE_MINUTE_BLINK);
      write_csr(CSR_DISPLAY_ON, 0);
      close_csr();
      push_random_ticks(20);
      wait_drained();

      write_csr(CSR_DISPLAY_ON, 1);
      write_csr(CSR_SCAN_PERIOD, 255);
      write_csr(CSR_BLINK_PERIOD, 4095);
      write_csr(CSR_DISPLAY_MODE, MODE_HOUR_BLINK);
      close_csr();
      push_random_ticks(300);
      wait_drained();

      while (ticks_queued < RANDOM_TICKS - 150) begin
         send_gap_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(40, 5);
         recv_gap_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(40, 5);
         if ($urandom_range(3) != 0) begin
            if ($urandom_range(1)) write_csr(CSR_DISPLAY_ON, with_noise($urandom_range(1), 1));
            if ($urandom_range(1)) begin
               n = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(4);
               write_csr(CSR_SCAN_PERIOD, with_noise(n, ScanPeriodWidth));
            end
            if ($urandom_range(1)) begin
               n = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(30);
               write_csr(CSR_BLINK_PERIOD, n);
            end
            if ($urandom_range(2) != 0)
               write_csr(CSR_DISPLAY_MODE, with_noise($urandom_range(3), ModeWidth));
            close_csr();
         end
         push_random_ticks($urandom_range(150, 50));
         wait_drained();
      end

      // Closing stretch at full rate with no idling on either side.
      send_gap_pct = 0;
      recv_gap_pct = 0;
      write_csr(CSR_DISPLAY_ON, 1);
      write_csr(CSR_SCAN_PERIOD, 2);
      write_csr(CSR_BLINK_PERIOD, 7);
      write_csr(CSR_DISPLAY_MODE, MODE_MINUTE_BLINK);
      close_csr();
      push_random_ticks(150);
      wait_drained();
      repeat (4) @(posedge clock);

      $display("Checked %0d results from %0d ticks over %0d phases and %0d register writes.",
               results_checked, ticks_accepted, phase_count, csr_writes);
      $display("The run saw %0d digit switches and %0d blink toggles.", switch_count,
               toggle_count);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
